>>> rtl/rwic_pkg.sv
package rwic_pkg;

  // Field and register widths
  localparam int REG_W  = 21;
  localparam int COV_W  = 40;
  localparam int BRK_W  = 16;
  localparam int LEN_W  = 32;
  localparam int PCT_W  = 7;
  localparam int QRT_W  = 2;
  localparam int BTOT_W = 2;
  localparam int IDX_W  = 2;

  // Coverage percent divider: quotient below 128, dividend below 100 * 2^21
  localparam int REM_W  = 28;
  localparam int DIV_W  = REG_W + PCT_W - 1;
  localparam int STEP_W = 3;

  typedef logic [IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t IDX_READ_LENGTH = 2'd0;
  localparam reg_idx_t IDX_MIN_ALN     = 2'd1;
  localparam reg_idx_t IDX_MIN_FLANK   = 2'd2;

  localparam logic [REG_W-1:0] RST_READ_LENGTH = 21'd20000;
  localparam logic [REG_W-1:0] RST_MIN_ALN     = 21'd100;
  localparam logic [REG_W-1:0] RST_MIN_FLANK   = 21'd100;

  localparam logic [COV_W-1:0]  COV_MAX   = {COV_W{1'b1}};
  localparam logic [BRK_W-1:0]  BRK_MAX   = {BRK_W{1'b1}};
  localparam logic [PCT_W-1:0]  PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_Q1    = 7'd25;
  localparam logic [PCT_W-1:0]  PCT_Q2    = 7'd50;
  localparam logic [PCT_W-1:0]  PCT_Q3    = 7'd75;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_DINIT,
    S_DSTEP,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic div_init;
    logic div_step;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_last;
  } status_t;

endpackage

>>> rtl/rwic_item_if.sv
interface rwic_item_if #(
  parameter int COORD_BITS = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] read_start;
  logic [COORD_BITS-1:0] interval_lo;
  logic [COORD_BITS-1:0] interval_hi;
  logic                  interval_valid;
  logic                  last_interval;

  modport source (
    output valid, read_start, interval_lo, interval_hi, interval_valid, last_interval,
    input  ready
  );

  modport sink (
    input  valid, read_start, interval_lo, interval_hi, interval_valid, last_interval,
    output ready
  );
endinterface

>>> rtl/rwic_result_if.sv
interface rwic_result_if
  import rwic_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [LEN_W-1:0]  overlap_len;
  logic              aln_counted;
  logic              break_here;
  logic              read_done;
  logic [PCT_W-1:0]  cov_pct;
  logic [QRT_W-1:0]  cov_quarter;
  logic [BTOT_W-1:0] break_total;
  logic              has_alignment;

  modport source (
    output valid, overlap_len, aln_counted, break_here, read_done,
           cov_pct, cov_quarter, break_total, has_alignment,
    input  ready
  );

  modport sink (
    input  valid, overlap_len, aln_counted, break_here, read_done,
           cov_pct, cov_quarter, break_total, has_alignment,
    output ready
  );
endinterface

>>> rtl/read_window_interval_coverage_unit.sv
// Read window interval coverage unit.
//
// Feed the alignment intervals of one read window on the item channel, one
// item per interval, with last_interval set on the final one (an item with
// interval_valid low carries no interval, e.g. for a read with none). Each
// accepted item gives exactly one item on the result channel: the overlap
// of the interval with the window, whether it counted as an alignment and
// whether it marks a break. The item that closes a read also carries the
// summary: coverage percent and quarter, break total and the hit flag.
// Write read_length, min_aln and min_flank on the wr_* port while idle.
//
// Sequence: an item is taken while idle, evaluated in the next cycle and loaded
// into the output register once that register is free; only then is the next
// item taken. A closing item first passes the percent divider (a setup state,
// then one quotient bit per cycle).
// Reset clears the controller, the coverage and break accumulators and puts
// the registers at 20000, 100 and 100. A stalled receiver holds the result
// in the output register; one more item is taken and evaluated behind it.
module read_window_interval_coverage_unit
  import rwic_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  rwic_item_if.sink           item,
  rwic_result_if.source       result,
  input  logic                wr_en,
  input  reg_idx_t            wr_index,
  input  logic [REG_W-1:0]    wr_data
);

  cmd_t    cmd;
  status_t status;

  // Sequence each item: capture, evaluate, divide on the closing item, push
  rwic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold registers, accumulators, divider and output register
  rwic_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .read_start     (item.read_start),
    .interval_lo    (item.interval_lo),
    .interval_hi    (item.interval_hi),
    .interval_valid (item.interval_valid),
    .last_interval  (item.last_interval),
    .overlap_len    (result.overlap_len),
    .aln_counted    (result.aln_counted),
    .break_here     (result.break_here),
    .read_done      (result.read_done),
    .cov_pct        (result.cov_pct),
    .cov_quarter    (result.cov_quarter),
    .break_total    (result.break_total),
    .has_alignment  (result.has_alignment)
  );

endmodule

>>> rtl/rwic_ctrl.sv
module rwic_ctrl
  import rwic_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CALC;
      end
      S_CALC: begin
        state_next = status.last ? S_DINIT : S_PUSH;
      end
      S_DINIT: begin
        state_next = S_DSTEP;
      end
      S_DSTEP: begin
        if (status.div_last) state_next = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CALC:  cmd.calc     = 1'b1;
      S_DINIT: cmd.div_init = 1'b1;
      S_DSTEP: cmd.div_step = 1'b1;
      S_PUSH:  cmd.push     = out_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> rtl/rwic_datapath.sv
module rwic_datapath
  import rwic_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic                  wr_en,
  input  reg_idx_t              wr_index,
  input  logic [REG_W-1:0]      wr_data,
  input  logic [COORD_BITS-1:0] read_start,
  input  logic [COORD_BITS-1:0] interval_lo,
  input  logic [COORD_BITS-1:0] interval_hi,
  input  logic                  interval_valid,
  input  logic                  last_interval,
  output logic [LEN_W-1:0]      overlap_len,
  output logic                  aln_counted,
  output logic                  break_here,
  output logic                  read_done,
  output logic [PCT_W-1:0]      cov_pct,
  output logic [QRT_W-1:0]      cov_quarter,
  output logic [BTOT_W-1:0]     break_total,
  output logic                  has_alignment
);

  // Wide enough for window end plus flank without wrap
  localparam int EW = COORD_BITS + REG_W + 1;

  logic [REG_W-1:0] read_length;
  logic [REG_W-1:0] min_aln;
  logic [REG_W-1:0] min_flank;

  logic [COORD_BITS-1:0] wlo;
  logic [COORD_BITS-1:0] lo;
  logic [COORD_BITS-1:0] hi;
  logic                  ivalid;
  logic                  ilast;

  logic [COV_W-1:0] coverage_sum;
  logic [BRK_W-1:0] break_counter;

  logic [REG_W-1:0] res_ov;
  logic             res_cnt;
  logic             res_brk;

  logic [REM_W-1:0]  rem;
  logic [DIV_W-1:0]  dv;
  logic [PCT_W-1:0]  quo;
  logic [STEP_W-1:0] step;
  logic              div_full;
  logic              div_zero;
  logic              hit;
  logic [BTOT_W-1:0] btot;

  logic [EW-1:0]     wlo_e, whi_e, lo_e, hi_e, mf_e, mlo_e, mhi_e, span;
  logic              rl_zero;
  logic              brk_lo, brk_hi;
  logic [REG_W-1:0]  ov_v;
  logic              counted;
  logic              brk;
  logic [COV_W:0]    sum_add;
  logic [REM_W-1:0]  dv_e;
  logic [PCT_W-1:0]  pct_sel;

  // Item arithmetic
  always_comb begin
    rl_zero = (read_length == '0);
    wlo_e   = EW'(wlo);
    lo_e    = EW'(lo);
    hi_e    = EW'(hi);
    mf_e    = EW'(min_flank);
    whi_e   = wlo_e + EW'(read_length) - EW'(1);
    mlo_e   = (lo_e > wlo_e) ? lo_e : wlo_e;
    mhi_e   = (hi_e < whi_e) ? hi_e : whi_e;
    span    = mhi_e - mlo_e + EW'(1);
    brk_lo  = (lo_e >= wlo_e + mf_e) && (lo_e + mf_e <= whi_e);
    brk_hi  = (hi_e >= wlo_e + mf_e) && (hi_e + mf_e <= whi_e);
    ov_v    = (ivalid && !rl_zero && mlo_e <= mhi_e) ? REG_W'(span) : '0;
    counted = ivalid && (ov_v >= min_aln);
    brk     = ivalid && !rl_zero && (brk_lo || brk_hi);
    sum_add = {1'b0, coverage_sum} + (COV_W+1)'(ov_v);
  end

  assign dv_e    = REM_W'(dv);
  assign pct_sel = !ilast ? '0 : div_zero ? '0 : div_full ? PCT_FULL : quo;

  assign status.last     = ilast;
  assign status.div_last = (step == STEP_LAST);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      read_length <= RST_READ_LENGTH;
      min_aln     <= RST_MIN_ALN;
      min_flank   <= RST_MIN_FLANK;
    end else if (wr_en) begin
      case (wr_index)
        IDX_READ_LENGTH: read_length <= wr_data;
        IDX_MIN_ALN:     min_aln     <= wr_data;
        IDX_MIN_FLANK:   min_flank   <= wr_data;
        default: ;
      endcase
    end
  end

  // Per-read accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      coverage_sum  <= '0;
      break_counter <= '0;
    end else if (cmd.calc) begin
      if (counted) begin
        coverage_sum <= sum_add[COV_W] ? COV_MAX : sum_add[COV_W-1:0];
      end
      if (brk && break_counter != BRK_MAX) begin
        break_counter <= break_counter + BRK_W'(1);
      end
    end else if (cmd.div_init) begin
      coverage_sum  <= '0;
      break_counter <= '0;
    end
  end

  // Item capture, per-item results and percent divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wlo    <= read_start;
      lo     <= interval_lo;
      hi     <= interval_hi;
      ivalid <= interval_valid;
      ilast  <= last_interval;
    end
    if (cmd.calc) begin
      res_ov  <= ov_v;
      res_cnt <= counted;
      res_brk <= brk;
    end
    if (cmd.div_init) begin
      // Below the full mark the sum fits the register width
      rem      <= REM_W'(coverage_sum[REG_W-1:0]) * REM_W'(PCT_FULL);
      dv       <= {read_length, {(PCT_W-1){1'b0}}};
      quo      <= '0;
      step     <= '0;
      div_full <= (coverage_sum >= COV_W'(read_length));
      div_zero <= rl_zero;
      hit      <= (coverage_sum >= COV_W'(min_aln));
      btot     <= (break_counter > BRK_W'(3)) ? 2'd3 : break_counter[BTOT_W-1:0];
    end
    if (cmd.div_step) begin
      if (rem >= dv_e) begin
        rem <= rem - dv_e;
        quo <= {quo[PCT_W-2:0], 1'b1};
      end else begin
        quo <= {quo[PCT_W-2:0], 1'b0};
      end
      dv   <= dv >> 1;
      step <= step + STEP_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      overlap_len   <= LEN_W'(res_ov);
      aln_counted   <= res_cnt;
      break_here    <= res_brk;
      read_done     <= ilast;
      cov_pct       <= pct_sel;
      cov_quarter   <= (pct_sel >= PCT_Q3) ? 2'd3 :
                       (pct_sel >= PCT_Q2) ? 2'd2 :
                       (pct_sel >= PCT_Q1) ? 2'd1 : 2'd0;
      break_total   <= ilast ? btot : '0;
      has_alignment <= ilast && hit;
    end
  end

endmodule
